// ----- hdl/piecewise_linear_interpolator_top_defines.svh -----
// assertion macros shared by the block
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_TOP_DEFINES_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PLWI_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("plwi: assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define PLWI_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("plwi: assertion failed");

`endif

// ----- hdl/plwi_pkg.sv -----
`timescale 1ns / 1ps
package plwi_pkg;

	localparam int unsigned MAX_POINTS  = 64;
	localparam int unsigned DATA_WIDTH  = 32;
	localparam int unsigned XW          = 32;
	localparam int unsigned IDX_W       = $clog2(MAX_POINTS);
	localparam int unsigned CNT_W       = $clog2(MAX_POINTS + 1);
	localparam int unsigned DIFF_W      = XW + 1;
	localparam int unsigned PROD_W      = 2 * XW;
	localparam int unsigned STEP_W      = $clog2(PROD_W + 1);
	localparam int unsigned SUM_W       = 36;
	localparam int unsigned MAG_LIM_BIT = 34;

	localparam logic signed [SUM_W-1:0] Y_MAX =
		SUM_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] Y_MIN = -Y_MAX - SUM_W'(1);

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_NOT_ASC = 2'd2,
		ST_FEW     = 2'd3
	} status_t;

	// search token handed from cell to cell
	typedef struct packed {
		logic                  valid;
		logic [IDX_W-1:0]      idx;
		logic signed [XW-1:0]  q;
		logic signed [XW-1:0]  x0;
		logic signed [XW-1:0]  y0;
		logic signed [XW-1:0]  x1;
		logic signed [XW-1:0]  y1;
		logic                  pending;
	} tok_t;

endpackage

// ----- hdl/plwi_req_if.sv -----
`timescale 1ns / 1ps
interface plwi_req_if import plwi_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [1:0]           opcode;
	logic signed [XW-1:0] x_value;
	logic signed [XW-1:0] y_in;

	modport source (output valid, output opcode, output x_value, output y_in, input ready);
	modport sink (input valid, input opcode, input x_value, input y_in, output ready);
endinterface

// ----- hdl/plwi_rsp_if.sv -----
`timescale 1ns / 1ps
interface plwi_rsp_if import plwi_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic signed [XW-1:0] y_out;
	logic [1:0]           status;
	logic                 saturated;

	modport source (output valid, output y_out, output status, output saturated, input ready);
	modport sink (input valid, input y_out, input status, input saturated, output ready);
endinterface

// ----- hdl/plwi_cell.sv -----
`timescale 1ns / 1ps
module plwi_cell import plwi_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [CNT_W-1:0]     cnt,
	input  logic                 we,
	input  logic signed [XW-1:0] wx,
	input  logic signed [XW-1:0] wy,
	input  tok_t                 tok_in,
	output tok_t                 tok_out
);

	logic signed [XW-1:0] x_q;
	logic signed [XW-1:0] y_q;
	logic                 valid_q;
	tok_t                 tok_n;
	tok_t                 tok_q;

	// breakpoint storage
	always_ff @(posedge clk) begin
		if (we) begin
			x_q <= wx;
			y_q <= wy;
		end
	end

	always_comb begin
		tok_n = tok_in;
		tok_n.idx = tok_in.idx + IDX_W'(1);
		// previous cell opened a segment: this entry closes it
		if (tok_in.pending) begin
			tok_n.x1 = x_q;
			tok_n.y1 = y_q;
			tok_n.pending = 1'b0;
		end
		if (tok_in.idx == '0) begin
			tok_n.x0 = x_q;
			tok_n.y0 = y_q;
			tok_n.pending = 1'b1;
		end else if ((CNT_W'(tok_in.idx) + CNT_W'(1) < cnt)
				&& ($signed(x_q) <= $signed(tok_in.q))) begin
			tok_n.x0 = x_q;
			tok_n.y0 = y_q;
			tok_n.pending = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_n;
	end

	always_comb begin
		tok_out = tok_q;
		tok_out.valid = valid_q;
	end

endmodule

// ----- hdl/plwi_div.sv -----
`timescale 1ns / 1ps
module plwi_div import plwi_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] dividend,
	input  logic [XW-1:0]     divisor,
	output logic              done,
	output logic [PROD_W-1:0] quotient
);

	logic [PROD_W-1:0] p_q;
	logic [XW-1:0]     rem_q;
	logic [XW-1:0]     dvs_q;
	logic [STEP_W-1:0] step_q;
	logic              run_q;
	logic              done_q;
	logic [XW:0]       sh;
	logic              ge;
	logic [XW:0]       diff;

	// restoring step: one quotient bit per cycle
	always_comb begin
		sh   = {rem_q, p_q[PROD_W-1]};
		ge   = sh >= {1'b0, dvs_q};
		diff = sh - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= run_q && !start && (step_q == STEP_W'(1));
			if (start) begin
				run_q  <= 1'b1;
				step_q <= STEP_W'(PROD_W);
			end else if (run_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			p_q   <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			p_q   <= {p_q[PROD_W-2:0], ge};
			rem_q <= ge ? diff[XW-1:0] : sh[XW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = p_q;

endmodule

// ----- hdl/piecewise_linear_interpolator_top.sv -----
`timescale 1ns / 1ps
// channel  dir  beat payload                       handshake
// req      in   opcode, x_value, y_in              valid/ready
// rsp      out  y_out, status, saturated           valid/ready
//
// clear, append, the unused opcode and a too-few-points query: the fsm goes to S_RESULT,
//   raises rsp valid from the output register once it is free and takes the next req beat in S_IDLE
// query: the token walks the whole cell row, then differences, abs, multiply, divider start,
//   64 divider steps, result and output register; the next req beat is taken back in S_IDLE
// arst_n clears the point count, the fsm and every valid flag; the table is not cleared
// req is taken while a finished beat waits on rsp; a stalled rsp holds the next result
`include "piecewise_linear_interpolator_top_defines.svh"
module piecewise_linear_interpolator_top import plwi_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	plwi_req_if.sink  req,
	plwi_rsp_if.source rsp
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_ABS,
		S_MUL,
		S_DIV,
		S_RESULT
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic signed [XW-1:0]  last_x_q;

	// result waiting for the output register
	logic signed [XW-1:0]  res_y_q;
	logic [1:0]            res_status_q;
	logic                  res_sat_q;

	// output register
	logic                  out_valid_q;
	logic signed [XW-1:0]  out_y_q;
	logic [1:0]            out_status_q;
	logic                  out_sat_q;

	// arithmetic pipeline
	logic [XW-1:0]         dx_q;
	logic signed [DIFF_W-1:0] dy_q;
	logic signed [DIFF_W-1:0] dq_q;
	logic signed [XW-1:0]  y0_q;
	logic [XW-1:0]         mdy_q;
	logic [XW-1:0]         mdq_q;
	logic                  neg_q;
	logic [PROD_W-1:0]     prod_q;
	logic                  div_start_q;

	logic                  acc;
	logic                  app_full;
	logic                  app_not_asc;
	logic                  app_ok;
	logic                  out_free;
	logic [MAX_POINTS-1:0] cell_we;
	tok_t                  tok_chain [MAX_POINTS+1];
	tok_t                  tok_end;

	logic [DIFF_W-1:0]     dx_full;
	logic signed [DIFF_W-1:0] dy_full;
	logic signed [DIFF_W-1:0] dq_full;
	logic [DIFF_W-1:0]     mdy_full;
	logic [DIFF_W-1:0]     mdq_full;

	logic                  div_done;
	logic [PROD_W-1:0]     quot;
	logic                  big;
	logic signed [SUM_W-1:0] base;
	logic signed [SUM_W-1:0] mag_s;
	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] y_fin;
	logic                  sat_fin;

	assign acc       = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign out_free  = !out_valid_q || rsp.ready;

	// append checks: full first, then ordering against the last stored x
	assign app_full    = (cnt_q == CNT_W'(MAX_POINTS));
	assign app_not_asc = (cnt_q != '0) && ($signed(req.x_value) <= $signed(last_x_q));
	assign app_ok      = acc && (req.opcode == OP_APPEND) && !app_full && !app_not_asc;

	// query token enters cell 0 on accept when the table holds at least two points
	always_comb begin
		tok_chain[0]         = '0;
		tok_chain[0].valid   = acc && (req.opcode == OP_QUERY) && (cnt_q >= CNT_W'(2));
		tok_chain[0].q       = req.x_value;
		tok_chain[0].pending = 1'b0;
	end

	// cell row: one breakpoint per cell, the token shifts one cell per cycle
	for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
		assign cell_we[i] = app_ok && (cnt_q == CNT_W'(i));

		plwi_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cnt     (cnt_q),
			.we      (cell_we[i]),
			.wx      (req.x_value),
			.wy      (req.y_in),
			.tok_in  (tok_chain[i]),
			.tok_out (tok_chain[i+1])
		);
	end

	assign tok_end = tok_chain[MAX_POINTS];

	// segment differences, 33 bits signed
	always_comb begin
		dx_full = {tok_end.x1[XW-1], tok_end.x1} - {tok_end.x0[XW-1], tok_end.x0};
		dy_full = {tok_end.y1[XW-1], tok_end.y1} - {tok_end.y0[XW-1], tok_end.y0};
		dq_full = {tok_end.q[XW-1], tok_end.q} - {tok_end.x0[XW-1], tok_end.x0};
	end

	// magnitudes fit in 32 bits
	always_comb begin
		mdy_full = dy_q[DIFF_W-1] ? (~dy_q + DIFF_W'(1)) : dy_q;
		mdq_full = dq_q[DIFF_W-1] ? (~dq_q + DIFF_W'(1)) : dq_q;
	end

	plwi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (prod_q),
		.divisor  (dx_q),
		.done     (div_done),
		.quotient (quot)
	);

	// final add and saturation, used in the cycle the divider finishes
	always_comb begin
		big   = quot > (PROD_W'(1) << MAG_LIM_BIT);
		base  = {{(SUM_W-XW){y0_q[XW-1]}}, y0_q};
		mag_s = {1'b0, quot[SUM_W-2:0]};
		sum   = neg_q ? (base - mag_s) : (base + mag_s);
		sat_fin = 1'b0;
		if (big) begin
			y_fin   = neg_q ? Y_MIN : Y_MAX;
			sat_fin = 1'b1;
		end else if (sum > Y_MAX) begin
			y_fin   = Y_MAX;
			sat_fin = 1'b1;
		end else if (sum < Y_MIN) begin
			y_fin   = Y_MIN;
			sat_fin = 1'b1;
		end else begin
			y_fin = sum;
		end
	end

	// control, table count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			res_y_q      <= '0;
			res_status_q <= ST_OK;
			res_sat_q    <= 1'b0;
			out_valid_q  <= 1'b0;
			out_y_q      <= '0;
			out_status_q <= ST_OK;
			out_sat_q    <= 1'b0;
			div_start_q  <= 1'b0;
		end else begin
			div_start_q <= (state_q == S_MUL);
			// a beat leaving while a new one loads is handled in S_RESULT
			if (out_valid_q && rsp.ready && (state_q != S_RESULT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						res_y_q   <= '0;
						res_sat_q <= 1'b0;
						case (req.opcode)
							OP_CLEAR: begin
								cnt_q        <= '0;
								res_status_q <= ST_OK;
								state_q      <= S_RESULT;
							end
							OP_APPEND: begin
								state_q <= S_RESULT;
								if (app_full) begin
									res_status_q <= ST_FULL;
								end else if (app_not_asc) begin
									res_status_q <= ST_NOT_ASC;
								end else begin
									res_status_q <= ST_OK;
									cnt_q        <= cnt_q + CNT_W'(1);
								end
							end
							OP_QUERY: begin
								if (cnt_q < CNT_W'(2)) begin
									res_status_q <= ST_FEW;
									state_q      <= S_RESULT;
								end else begin
									res_status_q <= ST_OK;
									state_q      <= S_SEARCH;
								end
							end
							default: begin
								// unused opcode: no effect, zero result
								res_status_q <= ST_OK;
								state_q      <= S_RESULT;
							end
						endcase
					end
				end
				S_SEARCH: begin
					if (tok_end.valid) begin
						state_q <= S_ABS;
					end
				end
				S_ABS: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						res_y_q      <= y_fin[XW-1:0];
						res_status_q <= ST_OK;
						res_sat_q    <= sat_fin;
						state_q      <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_y_q      <= res_y_q;
						out_status_q <= res_status_q;
						out_sat_q    <= res_sat_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (app_ok) begin
			last_x_q <= req.x_value;
		end
		if ((state_q == S_SEARCH) && tok_end.valid) begin
			dx_q <= dx_full[XW-1:0];
			dy_q <= dy_full;
			dq_q <= dq_full;
			y0_q <= tok_end.y0;
		end
		if (state_q == S_ABS) begin
			mdy_q <= mdy_full[XW-1:0];
			mdq_q <= mdq_full[XW-1:0];
			neg_q <= dy_q[DIFF_W-1] ^ dq_q[DIFF_W-1];
		end
		if (state_q == S_MUL) begin
			prod_q <= PROD_W'(mdy_q) * PROD_W'(mdq_q);
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.y_out     = out_y_q;
	assign rsp.status    = out_status_q;
	assign rsp.saturated = out_sat_q;

	// point count never passes the table size
	`PLWI_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= CNT_W'(MAX_POINTS))
	// an append to a full table leaves the count alone
	`PLWI_ASSERT_NXT(a_full_hold, acc && (req.opcode == OP_APPEND) && app_full, cnt_q == $past(cnt_q))
	// a token leaves the cell row only while the fsm waits for it
	`PLWI_ASSERT_IMP(a_tok_search, tok_end.valid, state_q == S_SEARCH)
	// the divider finishes only while the fsm waits for it
	`PLWI_ASSERT_IMP(a_div_state, div_done, state_q == S_DIV)

endmodule

// ----- bench/piecewise_linear_interpolator_top_tb.sv -----
`timescale 1ns / 1ps
module piecewise_linear_interpolator_top_tb;
	import plwi_pkg::*;

	localparam int          N_ITEMS      = 1450;
	localparam int          HOLD_CYCLES  = 3000;
	localparam int          DRAIN_CYCLES = 200;
	localparam longint      CYCLE_LIMIT  = 2_000_000;
	localparam logic [1:0]  OP_UNUSED    = 2'd3;
	localparam int          S32_MAX      = 32'sh7FFF_FFFF;
	localparam int          S32_MIN      = 32'sh8000_0000;

	// one expected rsp beat
	typedef struct {
		logic signed [XW-1:0] y;
		status_t              st;
		logic                 sat;
	} interp_result_t;

	// breakpoint table mirror plus the queue of answers still owed by the block
	class interp_scoreboard;
		logic signed [XW-1:0] bp_x [MAX_POINTS];
		logic signed [XW-1:0] bp_y [MAX_POINTS];
		int unsigned          n_points;
		interp_result_t       owed_q [$];
		int unsigned          errors;
		int unsigned          n_rsp;

		function new();
			n_points = 0;
			errors   = 0;
			n_rsp    = 0;
		endfunction

		// predict the answer to one accepted req beat
		function void note_request(logic [1:0] op, logic signed [XW-1:0] xv,
				logic signed [XW-1:0] yv);
			interp_result_t r;
			int unsigned    seg;
			longint         dx, dy, dq, t, ymax, ymin;
			bit [63:0]      ady, adq, mag;
			bit             neg;
			r.y   = '0;
			r.st  = ST_OK;
			r.sat = 1'b0;
			ymax  = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
			ymin  = -ymax - 1;
			case (op)
				OP_CLEAR: begin
					n_points = 0;
				end
				OP_APPEND: begin
					if (n_points >= MAX_POINTS)
						r.st = ST_FULL;
					else if (n_points > 0 && xv <= bp_x[n_points-1])
						r.st = ST_NOT_ASC;
					else begin
						bp_x[n_points] = xv;
						bp_y[n_points] = yv;
						n_points++;
					end
				end
				OP_QUERY: begin
					if (n_points < 2)
						r.st = ST_FEW;
					else begin
						// clamp to first / last segment so outside points extrapolate
						seg = 0;
						for (int k = 1; k + 1 < n_points; k++)
							if (bp_x[k] <= xv)
								seg = k;
						dx  = longint'(bp_x[seg+1]) - longint'(bp_x[seg]);
						dy  = longint'(bp_y[seg+1]) - longint'(bp_y[seg]);
						dq  = longint'(xv) - longint'(bp_x[seg]);
						ady = (dy < 0) ? -dy : dy;
						adq = (dq < 0) ? -dq : dq;
						mag = (ady * adq) / 64'(dx);
						neg = (dy < 0) != (dq < 0);
						if (mag > (64'd1 << 34)) begin
							r.y   = neg ? XW'(ymin) : XW'(ymax);
							r.sat = 1'b1;
						end else begin
							t = longint'(bp_y[seg]) + (neg ? -longint'(mag) : longint'(mag));
							if (t > ymax) begin
								t     = ymax;
								r.sat = 1'b1;
							end else if (t < ymin) begin
								t     = ymin;
								r.sat = 1'b1;
							end
							r.y = XW'(t);
						end
					end
				end
				default: ;
			endcase
			owed_q = {owed_q, r};
		endfunction

		function void check_response(logic signed [XW-1:0] y, logic [1:0] st, logic sat);
			interp_result_t e;
			n_rsp++;
			if (owed_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t rsp beat %0d: y_out %0d status %0d sat %0b with nothing owed",
						$realtime, n_rsp, y, st, sat);
			end else begin
				e = owed_q.pop_front();
				if (y !== e.y || st !== e.st || sat !== e.sat) begin
					errors++;
					if (errors <= 10)
						$display({"%0t rsp beat %0d: got y_out %0d status %0d sat %0b,",
							" want y_out %0d status %0d sat %0b"}, $realtime, n_rsp,
							y, st, sat, e.y, e.st, e.sat);
				end
			end
		endfunction

		function int unsigned outstanding();
			return owed_q.size();
		endfunction

		// answers never delivered count as failures too
		function void close_out();
			errors += owed_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	plwi_req_if req_ch ();
	plwi_rsp_if rsp_ch ();

	piecewise_linear_interpolator_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	interp_scoreboard sb = new();

	int     sent;
	bit     calm;      // sender runs back to back for this sequence
	bit     hold_off;  // raised by the stimulus, consumed by the rsp side
	longint cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int clip32(longint v);
		if (v > S32_MAX)
			return S32_MAX;
		if (v < S32_MIN)
			return S32_MIN;
		return int'(v);
	endfunction

	// uniform-ish pick in [0, span)
	function automatic longint rand_span(longint span);
		bit [63:0] r;
		r = {$urandom, $urandom};
		return longint'(r % 64'(span));
	endfunction

	// offer one req beat and hold it until the block takes it
	task automatic send(logic [1:0] op, int xv, int yv);
		int unsigned gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.opcode  <= op;
		req_ch.x_value <= xv;
		req_ch.y_in    <= yv;
		do @(posedge clk); while (!req_ch.ready);
		sent++;
	endtask

	task automatic directed_checks();
		// unused opcode and a query on an empty table
		send(OP_UNUSED, S32_MIN, S32_MAX);
		send(OP_QUERY, 0, -1);
		// single point is still too few
		send(OP_APPEND, 0, 0);
		send(OP_QUERY, 0, 0);
		// equal and smaller x are refused
		send(OP_APPEND, 0, 5);
		send(OP_APPEND, -1, 5);
		// steep segment: far queries overflow the magnitude limit both ways
		send(OP_APPEND, 1, S32_MAX);
		send(OP_QUERY, S32_MAX, 0);
		send(OP_QUERY, S32_MIN, 0);
		// small magnitude: above the table the sum runs past the top of the range, below it does not
		send(OP_CLEAR, -1, -1);
		send(OP_APPEND, 0, 32'sh7FFF_0000);
		send(OP_APPEND, 1, S32_MAX);
		send(OP_QUERY, 2, 0);
		send(OP_QUERY, -2, 0);
		// full x and y range in one table
		send(OP_CLEAR, 0, 0);
		send(OP_APPEND, S32_MIN, S32_MAX);
		send(OP_APPEND, 0, 0);
		send(OP_APPEND, S32_MAX, S32_MIN);
		send(OP_QUERY, S32_MIN, 0);
		send(OP_QUERY, 0, 0);
		send(OP_QUERY, S32_MAX, 0);
		send(OP_QUERY, -196608, 0);
		// extrapolation on both sides
		send(OP_CLEAR, 0, 0);
		send(OP_APPEND, -10 <<< 16, 5 <<< 16);
		send(OP_APPEND, 10 <<< 16, -5 <<< 16);
		send(OP_QUERY, -20 <<< 16, 0);
		send(OP_QUERY, 20 <<< 16, 0);
	endtask

	// usually clear, load an ascending table, then ask a handful of queries
	task automatic load_and_query();
		int          xs [$];
		int unsigned npts, nq, r, shape;
		bit          wide_y;
		longint      acc, lo, hi, q;
		int          yv;
		if ($urandom_range(0, 9) != 0)
			send(OP_CLEAR, int'($urandom), int'($urandom));
		r = $urandom_range(0, 99);
		if (r < 70)
			npts = $urandom_range(2, 8);
		else if (r < 88)
			npts = $urandom_range(9, 30);
		else if (r < 95)
			npts = $urandom_range(0, 1);
		else
			npts = $urandom_range(MAX_POINTS - 4, MAX_POINTS + 2);  // may run into a full table
		shape  = $urandom_range(0, 2);
		wide_y = $urandom_range(0, 1);
		acc    = longint'(int'($urandom)) / 2;
		repeat (npts) begin
			case (shape)
				0: xs = {xs, int'($urandom)};
				1: begin
					xs = {xs, clip32(acc)};
					acc += $urandom_range(1, 1 << 18);
				end
				default: begin
					// tiny dx gives steep slopes
					xs = {xs, clip32(acc)};
					acc += $urandom_range(1, 4);
				end
			endcase
		end
		if (shape == 0)
			xs.sort();
		foreach (xs[i]) begin
			yv = wide_y ? int'($urandom) : int'($urandom_range(0, 1 << 21)) - (1 << 20);
			// now and then a stale x to break the order
			if (i > 0 && $urandom_range(0, 19) == 0)
				send(OP_APPEND, xs[i-1] - int'($urandom_range(0, 3)), int'($urandom));
			send(OP_APPEND, xs[i], yv);
		end
		nq = $urandom_range(1, 10);
		repeat (nq) begin
			r = $urandom_range(0, 99);
			if (xs.size() == 0 || (r >= 60 && r < 80))
				q = longint'(int'($urandom));
			else begin
				lo = xs[0];
				hi = xs[xs.size()-1];
				if (r < 40)
					q = lo + rand_span(hi - lo + 1);
				else if (r < 60)
					q = xs[$urandom_range(0, xs.size() - 1)];
				else if (r < 90)
					q = hi + $urandom_range(1, 1 << 20);
				else
					q = lo - $urandom_range(1, 1 << 20);
			end
			if ($urandom_range(0, 19) == 0)
				send(OP_UNUSED, int'($urandom), int'($urandom));
			send(OP_QUERY, clip32(q), int'($urandom));
		end
	endtask

	// req beat monitor feeds the predictor
	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready)
			sb.note_request(req_ch.opcode, req_ch.x_value, req_ch.y_in);
	end

	// rsp beat monitor
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_response(rsp_ch.y_out, rsp_ch.status, rsp_ch.saturated);
	end

	// rsp side backpressure, including one long hold-off that fills the block
	initial begin
		int unsigned r;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (hold_off) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end else if (r < 8) begin
				rsp_ch.ready <= 1'b1;
				repeat (200) @(posedge clk);
			end else if (r < 55) begin
				rsp_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b0;
				repeat (pick_gap() + 1) @(posedge clk);
			end
		end
	end

	// watchdog
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Mismatches found");
		$finish;
	end

	initial begin
		bit hold_done;
		hold_done      = 1'b0;
		hold_off       = 1'b0;
		calm           = 1'b0;
		sent           = 0;
		arst_n         <= 1'b0;
		req_ch.valid   <= 1'b0;
		req_ch.opcode  <= OP_CLEAR;
		req_ch.x_value <= '0;
		req_ch.y_in    <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_checks();

		while (sent < N_ITEMS) begin
			calm = ($urandom_range(0, 6) == 0);
			// once, keep rsp blocked while req keeps coming
			if (!hold_done && sent > 400) begin
				hold_off  = 1'b1;
				hold_done = 1'b1;
			end
			if ($urandom_range(0, 99) < 8) begin
				// noise: any opcode, any fields
				repeat ($urandom_range(1, 5))
					send(2'($urandom_range(0, 3)), int'($urandom), int'($urandom));
			end else
				load_and_query();
		end
		req_ch.valid <= 1'b0;

		while (sb.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.close_out();
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/plwi_pkg.sv
hdl/plwi_req_if.sv
hdl/plwi_rsp_if.sv
hdl/plwi_cell.sv
hdl/plwi_div.sv
hdl/piecewise_linear_interpolator_top.sv
bench/piecewise_linear_interpolator_top_tb.sv
